[hw/rtl/pll_pkg.sv]
package pll_pkg;

  localparam int REQ_W    = 2;
  localparam int POS_W    = 7;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int FOUND_W  = 6;
  localparam int LEN_W    = 7;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_POS   = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic {
    CTRL_IDLE = 1'b0,
    CTRL_SCAN = 1'b1
  } ctrl_state_t;

  // command broadcast to every cell of the chain
  typedef enum logic [2:0] {
    OP_HOLD  = 3'd0,
    OP_INS   = 3'd1,
    OP_REM   = 3'd2,
    OP_CMP   = 3'd3,
    OP_SHIFT = 3'd4
  } cell_op_t;

endpackage

[hw/rtl/pll_cell.sv]
module pll_cell #(
  parameter int POOL_DEPTH = 64,
  parameter int DATA_WIDTH = 32,
  parameter int CELL_IDX   = 0,
  parameter int CNT_W      = $clog2(POOL_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pll_pkg::cell_op_t     op,
  input  logic [CNT_W-1:0]      pos,
  input  logic [DATA_WIDTH-1:0] key,
  input  logic [CNT_W-1:0]      list_len,
  input  logic [DATA_WIDTH-1:0] left_value,
  input  logic [DATA_WIDTH-1:0] right_value,
  input  logic                  right_match,
  output logic [DATA_WIDTH-1:0] value,
  output logic                  match
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(CELL_IDX);

  logic [DATA_WIDTH-1:0] value_r, value_nxt;
  logic                  match_r, match_nxt;

  always_comb begin
    value_nxt = value_r;
    match_nxt = match_r;
    case (op)
      pll_pkg::OP_INS: begin
        if (MY_IDX > pos) begin
          value_nxt = left_value;
        end else if (MY_IDX == pos) begin
          value_nxt = key;
        end
      end
      pll_pkg::OP_REM: begin
        if (MY_IDX >= pos) begin
          value_nxt = right_value;
        end
      end
      // only cells inside the list may flag a hit
      pll_pkg::OP_CMP:   match_nxt = (value_r == key) && (MY_IDX < list_len);
      pll_pkg::OP_SHIFT: match_nxt = right_match;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

  assign value = value_r;
  assign match = match_r;

endmodule

[hw/rtl/pll_ctrl.sv]
module pll_ctrl #(
  parameter int POOL_DEPTH = 64,
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = $clog2(POOL_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pll_pkg::REQ_W-1:0]     in_req_type,
  input  logic [pll_pkg::POS_W-1:0]     in_list_position,
  input  logic [pll_pkg::VALUE_W-1:0]   in_element_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pll_pkg::STATUS_W-1:0]  out_status,
  output logic [pll_pkg::FOUND_W-1:0]   out_found_position,
  output logic [pll_pkg::LEN_W-1:0]     out_current_length,
  output pll_pkg::cell_op_t             cell_op,
  output logic [CNT_W-1:0]              cell_pos,
  output logic [DATA_WIDTH-1:0]         cell_key,
  output logic [CNT_W-1:0]              list_len,
  input  logic                          head_match
);

  localparam int CMP_W = (CNT_W > pll_pkg::POS_W) ? CNT_W : pll_pkg::POS_W;
  localparam int KEY_W = (DATA_WIDTH < pll_pkg::VALUE_W) ? DATA_WIDTH : pll_pkg::VALUE_W;
  localparam logic [CNT_W-1:0] FULL = CNT_W'(POOL_DEPTH);

  pll_pkg::ctrl_state_t state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     scan_r, scan_nxt;
  logic                 out_valid_r, out_valid_nxt;
  pll_pkg::status_t     out_status_r, out_status_nxt;
  logic [CNT_W-1:0]     out_found_r, out_found_nxt;
  logic [CNT_W-1:0]     out_len_r, out_len_nxt;

  logic out_free;
  logic accept;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] count_ext;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == pll_pkg::CTRL_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign pos_ext   = CMP_W'(in_list_position);
  assign count_ext = CMP_W'(count_r);

  always_comb begin
    cell_key = '0;
    cell_key[KEY_W-1:0] = in_element_value[KEY_W-1:0];
  end

  assign cell_pos = CNT_W'(in_list_position);
  assign list_len = count_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    scan_nxt       = scan_r;
    cell_op        = pll_pkg::OP_HOLD;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_len_nxt    = out_len_r;
    case (state_r)
      pll_pkg::CTRL_IDLE: begin
        if (accept) begin
          case (pll_pkg::req_t'(in_req_type))
            pll_pkg::REQ_INSERT: begin
              out_valid_nxt = 1'b1;
              out_found_nxt = '0;
              out_len_nxt   = count_r;
              if (pos_ext > count_ext) begin
                out_status_nxt = pll_pkg::ST_BAD_POS;
              end else if (count_r == FULL) begin
                out_status_nxt = pll_pkg::ST_EXHAUSTED;
              end else begin
                cell_op        = pll_pkg::OP_INS;
                count_nxt      = count_r + 1'b1;
                out_status_nxt = pll_pkg::ST_OK;
                out_len_nxt    = count_r + 1'b1;
              end
            end
            pll_pkg::REQ_REMOVE: begin
              out_valid_nxt = 1'b1;
              out_found_nxt = '0;
              out_len_nxt   = count_r;
              if (pos_ext >= count_ext) begin
                out_status_nxt = pll_pkg::ST_BAD_POS;
              end else begin
                cell_op        = pll_pkg::OP_REM;
                count_nxt      = count_r - 1'b1;
                out_status_nxt = pll_pkg::ST_OK;
                out_len_nxt    = count_r - 1'b1;
              end
            end
            pll_pkg::REQ_SEARCH: begin
              cell_op   = pll_pkg::OP_CMP;
              scan_nxt  = '0;
              state_nxt = pll_pkg::CTRL_SCAN;
            end
            default: begin
              count_nxt      = '0;
              out_valid_nxt  = 1'b1;
              out_status_nxt = pll_pkg::ST_OK;
              out_found_nxt  = '0;
              out_len_nxt    = '0;
            end
          endcase
        end
      end
      pll_pkg::CTRL_SCAN: begin
        // hit flags slide toward cell 0, one position per cycle while the output is free
        if (out_free) begin
          if (scan_r == count_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = pll_pkg::ST_NOT_FOUND;
            out_found_nxt  = '0;
            out_len_nxt    = count_r;
            state_nxt      = pll_pkg::CTRL_IDLE;
          end else if (head_match) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = pll_pkg::ST_OK;
            out_found_nxt  = scan_r;
            out_len_nxt    = count_r;
            state_nxt      = pll_pkg::CTRL_IDLE;
          end else begin
            cell_op  = pll_pkg::OP_SHIFT;
            scan_nxt = scan_r + 1'b1;
          end
        end
      end
      default: state_nxt = pll_pkg::CTRL_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pll_pkg::CTRL_IDLE;
      count_r     <= '0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_len_r    <= out_len_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_position = pll_pkg::FOUND_W'(out_found_r);
  assign out_current_length = pll_pkg::LEN_W'(out_len_r);

endmodule

[hw/rtl/pooled_linked_list_engine_unit.sv]
// Insert, remove and clear: the result is registered in the cycle after accept.
// Search: while the output is free, hit flags shift one cell per cycle toward the head
// of the cell chain, so scan length follows the hit position; the input waits until done.
// Throughput: insert, remove and clear one item per cycle while the output is not stalled.
// Reset empties the list; cell data is left as is and is never read before written.
module pooled_linked_list_engine_unit #(
  parameter int POOL_DEPTH = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pll_pkg::REQ_W-1:0]     in_req_type,
  input  logic [pll_pkg::POS_W-1:0]     in_list_position,
  input  logic [pll_pkg::VALUE_W-1:0]   in_element_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pll_pkg::STATUS_W-1:0]  out_status,
  output logic [pll_pkg::FOUND_W-1:0]   out_found_position,
  output logic [pll_pkg::LEN_W-1:0]     out_current_length
);

  localparam int CNT_W = $clog2(POOL_DEPTH + 1);

  pll_pkg::cell_op_t     cell_op;
  logic [CNT_W-1:0]      cell_pos;
  logic [DATA_WIDTH-1:0] cell_key;
  logic [CNT_W-1:0]      list_len;

  logic [DATA_WIDTH-1:0] value [POOL_DEPTH];
  logic                  match [POOL_DEPTH];

  pll_ctrl #(
    .POOL_DEPTH (POOL_DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_list_position   (in_list_position),
    .in_element_value   (in_element_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_found_position (out_found_position),
    .out_current_length (out_current_length),
    .cell_op            (cell_op),
    .cell_pos           (cell_pos),
    .cell_key           (cell_key),
    .list_len           (list_len),
    .head_match         (match[0])
  );

  for (genvar i = 0; i < POOL_DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_value;
    logic [DATA_WIDTH-1:0] right_value;
    logic                  right_match;

    if (i == 0) begin : g_first
      assign left_value = value[i];
    end else begin : g_mid_l
      assign left_value = value[i-1];
    end

    if (i == POOL_DEPTH - 1) begin : g_last
      assign right_value = value[i];
      assign right_match = 1'b0;
    end else begin : g_mid_r
      assign right_value = value[i+1];
      assign right_match = match[i+1];
    end

    pll_cell #(
      .POOL_DEPTH (POOL_DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .CELL_IDX   (i),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .op          (cell_op),
      .pos         (cell_pos),
      .key         (cell_key),
      .list_len    (list_len),
      .left_value  (left_value),
      .right_value (right_value),
      .right_match (right_match),
      .value       (value[i]),
      .match       (match[i])
    );
  end

endmodule

[tb/pooled_linked_list_engine_unit_checker.sv]
`timescale 1ns / 1ps
module pooled_linked_list_engine_unit_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [pll_pkg::REQ_W-1:0]     in_req_type,
  input  logic [pll_pkg::POS_W-1:0]     in_list_position,
  input  logic [pll_pkg::VALUE_W-1:0]   in_element_value,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [pll_pkg::STATUS_W-1:0]  out_status,
  input  logic [pll_pkg::FOUND_W-1:0]   out_found_position,
  input  logic [pll_pkg::LEN_W-1:0]     out_current_length,
  output int                            error_count,
  output int                            pending_results,
  output int                            list_length
);

  localparam int POOL_DEPTH = 64;

  typedef struct packed {
    pll_pkg::status_t             status;
    logic [pll_pkg::FOUND_W-1:0]  found;
    logic [pll_pkg::LEN_W-1:0]    len;
  } list_result_t;

  // list contents front to back; node indices never show at the outputs
  logic [pll_pkg::VALUE_W-1:0] list_values[$];
  list_result_t                expected_results[$];

  function automatic list_result_t serve_request(pll_pkg::req_t kind,
                                                 logic [pll_pkg::POS_W-1:0] pos,
                                                 logic [pll_pkg::VALUE_W-1:0] val);
    list_result_t r;
    int           idx;
    r.status = pll_pkg::ST_OK;
    r.found  = '0;
    case (kind)
      pll_pkg::REQ_INSERT: begin
        // position is checked before the pool
        if (pos > list_values.size()) r.status = pll_pkg::ST_BAD_POS;
        else if (list_values.size() >= POOL_DEPTH) r.status = pll_pkg::ST_EXHAUSTED;
        else list_values.insert(pos, val);
      end
      pll_pkg::REQ_REMOVE: begin
        if (pos >= list_values.size()) r.status = pll_pkg::ST_BAD_POS;
        else list_values.delete(pos);
      end
      pll_pkg::REQ_SEARCH: begin
        r.status = pll_pkg::ST_NOT_FOUND;
        for (idx = 0; idx < list_values.size(); idx++) begin
          if (list_values[idx] == val) begin
            r.status = pll_pkg::ST_OK;
            r.found  = pll_pkg::FOUND_W'(idx);
            break;
          end
        end
      end
      default: list_values.delete();
    endcase
    r.len = pll_pkg::LEN_W'(list_values.size());
    return r;
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    int           errs;
    errs = 0;
    if (!rst_n) begin
      error_count     <= 0;
      pending_results <= 0;
      list_length     <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected item: out_status %0d out_found_position %0d out_current_length %0d",
                 out_status, out_found_position, out_current_length);
          errs++;
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status) begin
            $error("out_status: expected %0d, got %0d", want.status, out_status);
            errs++;
          end
          if (out_found_position !== want.found) begin
            $error("out_found_position: expected %0d, got %0d", want.found, out_found_position);
            errs++;
          end
          if (out_current_length !== want.len) begin
            $error("out_current_length: expected %0d, got %0d", want.len, out_current_length);
            errs++;
          end
        end
      end
      // a result never leaves on the edge that takes its request
      if (in_valid && in_ready)
        expected_results.push_back(serve_request(pll_pkg::req_t'(in_req_type),
                                                 in_list_position, in_element_value));
      error_count     <= error_count + errs;
      pending_results <= expected_results.size();
      list_length     <= list_values.size();
    end
  end

endmodule

[tb/pooled_linked_list_engine_unit_tb.sv]
`timescale 1ns / 1ps
module pooled_linked_list_engine_unit_tb;

  localparam int POOL_DEPTH      = 64;
  localparam int DATA_WIDTH      = 32;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int MIX_SPAN        = 90;
  localparam int CYCLE_LIMIT     = 400000;

  typedef enum int {
    MIX_GROW     = 0,
    MIX_SHRINK   = 1,
    MIX_BALANCED = 2
  } mix_t;

  logic                          clk;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [pll_pkg::REQ_W-1:0]     in_req_type = pll_pkg::REQ_INSERT;
  logic [pll_pkg::POS_W-1:0]     in_list_position = '0;
  logic [pll_pkg::VALUE_W-1:0]   in_element_value = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [pll_pkg::STATUS_W-1:0]  out_status;
  logic [pll_pkg::FOUND_W-1:0]   out_found_position;
  logic [pll_pkg::LEN_W-1:0]     out_current_length;

  int error_count;
  int pending_results;
  int list_length;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int cycle_count = 0;

  // recent insert values, so searches can hit anywhere in the list
  logic [pll_pkg::VALUE_W-1:0] inserted_values[$];

  pooled_linked_list_engine_unit #(
    .POOL_DEPTH(POOL_DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_list_position  (in_list_position),
    .in_element_value  (in_element_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_found_position(out_found_position),
    .out_current_length(out_current_length)
  );

  pooled_linked_list_engine_unit_checker result_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_list_position  (in_list_position),
    .in_element_value  (in_element_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_found_position(out_found_position),
    .out_current_length(out_current_length),
    .error_count       (error_count),
    .pending_results   (pending_results),
    .list_length       (list_length)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("pooled_linked_list_engine_unit_tb: errors");
      $finish;
    end
  end

  function automatic logic [pll_pkg::VALUE_W-1:0] pick_common_value();
    case ($urandom_range(5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h0000_0001;
      3:       return 32'h8000_0000;
      4:       return 32'h5A5A_A5A5;
      default: return 32'h1234_5678;
    endcase
  endfunction

  task automatic send_item(pll_pkg::req_t kind, logic [pll_pkg::POS_W-1:0] pos,
                           logic [pll_pkg::VALUE_W-1:0] val);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid         <= 1'b1;
    in_req_type      <= kind;
    in_list_position <= pos;
    in_element_value <= val;
    if (kind == pll_pkg::REQ_INSERT) begin
      inserted_values.push_back(val);
      if (inserted_values.size() > POOL_DEPTH) void'(inserted_values.pop_front());
    end
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  initial begin
    int                          phase;
    int                          k;
    int                          roll;
    int                          len;
    mix_t                        mix;
    pll_pkg::req_t               kind;
    logic [pll_pkg::POS_W-1:0]   pos;
    logic [pll_pkg::VALUE_W-1:0] val;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 26;
          rx_idle_pct = 52;
        end
        1: begin
          tx_idle_pct = 52;
          rx_idle_pct = 26;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase

      if (phase == 0) begin
        send_item(pll_pkg::REQ_REMOVE, 7'd0, 32'h0);            // remove on empty list
        send_item(pll_pkg::REQ_SEARCH, 7'd0, 32'h0);            // search on empty list
        send_item(pll_pkg::REQ_INSERT, 7'd1, 32'hFFFF_FFFF);    // past the end
        send_item(pll_pkg::REQ_INSERT, 7'd0, 32'h0000_0000);
        send_item(pll_pkg::REQ_INSERT, 7'd1, 32'hFFFF_FFFF);    // append
        send_item(pll_pkg::REQ_INSERT, 7'd0, 32'h5555_AAAA);    // front
        send_item(pll_pkg::REQ_INSERT, 7'd1, 32'hAAAA_5555);    // middle
        send_item(pll_pkg::REQ_INSERT, 7'd127, 32'h0000_0001);  // all position bits
        send_item(pll_pkg::REQ_INSERT, 7'd2, 32'hFFFF_FFFF);    // duplicate value
        send_item(pll_pkg::REQ_SEARCH, 7'd0, 32'hFFFF_FFFF);    // first of two matches
        send_item(pll_pkg::REQ_SEARCH, 7'd0, 32'h0000_0000);
        send_item(pll_pkg::REQ_SEARCH, 7'd0, 32'h5555_AAAA);
        send_item(pll_pkg::REQ_SEARCH, 7'd0, 32'h1234_5678);    // miss
        send_item(pll_pkg::REQ_REMOVE, 7'd5, 32'h0);            // position == length
        send_item(pll_pkg::REQ_REMOVE, 7'd4, 32'h0);            // tail
        send_item(pll_pkg::REQ_REMOVE, 7'd1, 32'h0);
        send_item(pll_pkg::REQ_REMOVE, 7'd0, 32'h0);            // head
        send_item(pll_pkg::REQ_SEARCH, 7'd0, 32'h0000_0000);
        send_item(pll_pkg::REQ_CLEAR, 7'd0, 32'h0);
        send_item(pll_pkg::REQ_CLEAR, 7'd0, 32'h0);             // clear on empty
        send_item(pll_pkg::REQ_INSERT, 7'd64, 32'h7FFF_FFFF);
        send_item(pll_pkg::REQ_INSERT, 7'd0, 32'h7FFF_FFFF);
        send_item(pll_pkg::REQ_REMOVE, 7'd0, 32'h0);
        send_item(pll_pkg::REQ_REMOVE, 7'd0, 32'h0);
        drain_results();
      end

      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        mix  = mix_t'(((phase * ITEMS_PER_PHASE + k) / MIX_SPAN) % 3);
        len  = list_length;
        roll = $urandom_range(99);
        case (mix)
          MIX_GROW: begin
            if (roll < 90) kind = pll_pkg::REQ_INSERT;
            else if (roll < 97) kind = pll_pkg::REQ_SEARCH;
            else kind = pll_pkg::REQ_REMOVE;
          end
          MIX_SHRINK: begin
            if (roll < 20) kind = pll_pkg::REQ_INSERT;
            else if (roll < 42) kind = pll_pkg::REQ_SEARCH;
            else if (roll < 98) kind = pll_pkg::REQ_REMOVE;
            else kind = pll_pkg::REQ_CLEAR;
          end
          default: begin
            if (roll < 38) kind = pll_pkg::REQ_INSERT;
            else if (roll < 64) kind = pll_pkg::REQ_SEARCH;
            else if (roll < 95) kind = pll_pkg::REQ_REMOVE;
            else kind = pll_pkg::REQ_CLEAR;
          end
        endcase

        // list_length can trail by the item just taken; only the mix suffers
        roll = $urandom_range(99);
        if (kind == pll_pkg::REQ_SEARCH || kind == pll_pkg::REQ_CLEAR || roll < 8)
          pos = pll_pkg::POS_W'($urandom_range(127));
        else if (roll < 18)
          pos = pll_pkg::POS_W'((kind == pll_pkg::REQ_REMOVE && len > 0) ? len - 1 : len);
        else if (kind == pll_pkg::REQ_REMOVE)
          pos = pll_pkg::POS_W'((len > 0) ? $urandom_range(len - 1) : 0);
        else
          pos = pll_pkg::POS_W'($urandom_range(len));

        roll = $urandom_range(99);
        if (kind == pll_pkg::REQ_INSERT)
          val = (roll < 30) ? pick_common_value() : pll_pkg::VALUE_W'($urandom);
        else if (kind == pll_pkg::REQ_SEARCH && roll < 55 && inserted_values.size() > 0)
          val = inserted_values[$urandom_range(inserted_values.size() - 1)];
        else if (kind == pll_pkg::REQ_SEARCH && roll < 75)
          val = pick_common_value();
        else
          val = pll_pkg::VALUE_W'($urandom);

        if ($urandom_range(199) == 0) drain_results();
        send_item(kind, pos, val);
      end
      drain_results();
    end

    in_valid <= 1'b0;
    while (pending_results != 0) @(posedge clk);
    repeat (POOL_DEPTH + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("pooled_linked_list_engine_unit_tb: clean");
    end else begin
      $display("pooled_linked_list_engine_unit_tb: errors");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/pll_pkg.sv
hw/rtl/pll_cell.sv
hw/rtl/pll_ctrl.sv
hw/rtl/pooled_linked_list_engine_unit.sv
tb/pooled_linked_list_engine_unit_checker.sv
tb/pooled_linked_list_engine_unit_tb.sv
